/* design/pem_pkg.sv */
package pem_pkg;

   localparam int PIX_W    = 8;
   localparam int GRAD_W   = 11;  // signed gradient, range -765..765
   localparam int ABS_W    = 10;  // magnitude of one gradient, 0..765
   localparam int SQ_W     = 21;  // sum of two squares, below 2^21
   localparam int ROOT_W   = 11;  // floor root of SQ_W bits
   localparam int ROW_W    = 12;
   localparam int COL_W    = 11;
   localparam int CFG_W    = 13;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_USE_EUCLIDEAN = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load_pixel;   // capture request pixel, start line store reads
      logic shift_window; // shift window, write line stores
      logic calc_grad;    // register absolute gradients
      logic calc_square;  // register sum of squares
      logic root_start;   // load the root unit
      logic root_step;    // one root iteration
      logic load_result;  // fill the output register
   } cmd_type;

   typedef struct packed {
      logic interior;     // captured pixel produces a result
      logic euclid;
      logic root_done;
   } status_type;

endpackage

/* design/pem_ram.sv */
module pem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pem_ctrl.sv */
module pem_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pem_pkg::status_type status,
   output pem_pkg::cmd_type    cmd
);
   import pem_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            cmd.shift_window = 1'b1;
            state_in = status.interior ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            cmd.calc_grad = 1'b1;
            state_in = status.euclid ? ST_SQUARE : ST_OUTPUT;
         end
         ST_SQUARE: begin
            cmd.calc_square = 1'b1;
            cmd.root_start  = 1'b1;
            state_in        = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // The output register must be empty or emptying this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/pem_datapath.sv */
module pem_datapath #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pem_pkg::PIX_W-1:0]   req_pixel,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [pem_pkg::CFG_W-1:0]   csr_data,
   input  pem_pkg::cmd_type            cmd,
   output pem_pkg::status_type         status,
   output logic [pem_pkg::PIX_W-1:0]   rsp_magnitude,
   output logic [pem_pkg::ROW_W-1:0]   rsp_row,
   output logic [pem_pkg::COL_W-1:0]   rsp_col,
   output logic                        rsp_last_of_frame
);
   import pem_pkg::*;

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int IT_W = $clog2(ROOT_W + 1);

   // configuration
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic        euclid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         euclid_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   width_ff  <= csr_data[11:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_data;
            REG_USE_EUCLIDEAN: euclid_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   always_comb begin
      if (width_ff < 12'd3) begin
         eff_w = CW'(3);
      end else if ({{(CW > 12 ? CW - 12 : 0){1'b0}}, width_ff} > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(width_ff);
      end
      if (height_ff < 13'd3) begin
         eff_h = HW'(3);
      end else if (height_ff > 13'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_ff);
      end
   end

   // counters and captured pixel
   logic [CW-1:0]    col_ff;
   logic [HW-1:0]    row_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [CW-1:0]    cur_col_ff;
   logic [HW-1:0]    cur_row_ff;
   logic             interior_ff;
   logic             last_ff;
   logic [AW-1:0]    addr_ff;
   logic [CW-1:0]    col_next;
   logic [HW-1:0]    row_next;

   always_comb begin
      col_next = col_ff + CW'(1);
      row_next = row_ff;
      if (col_next >= eff_w) begin
         col_next = '0;
         row_next = row_ff + HW'(1);
         if (row_next >= eff_h) begin
            row_next = '0;
         end
      end
      if (row_next >= eff_h) begin
         row_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load_pixel) begin
         col_ff <= col_next;
         row_ff <= row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_ff      <= req_pixel;
         cur_col_ff  <= col_ff;
         cur_row_ff  <= row_ff;
         addr_ff     <= col_ff[AW-1:0];
         interior_ff <= col_ff >= CW'(2) && row_ff >= HW'(2)
                        && col_ff < eff_w && row_ff < eff_h;
         last_ff     <= (col_ff == eff_w - CW'(1)) && (row_ff == eff_h - HW'(1));
      end
   end

   // line stores, read in the capture cycle, written during the window shift
   logic [PIX_W-1:0] rd_a, rd_b;

   pem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
      .clock  (clock),
      .wr_en  (cmd.shift_window),
      .wr_addr(addr_ff),
      .wr_data(pix_ff),
      .rd_addr(col_ff[AW-1:0]),
      .rd_data(rd_a)
   );

   pem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
      .clock  (clock),
      .wr_en  (cmd.shift_window),
      .wr_addr(addr_ff),
      .wr_data(rd_a),
      .rd_addr(col_ff[AW-1:0]),
      .rd_data(rd_b)
   );

   // window, row-major with index 0 at top left
   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.shift_window) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= rd_b;
         win_ff[5] <= rd_a;
         win_ff[8] <= pix_ff;
      end
   end

   // gradients
   logic signed [GRAD_W-1:0] gx, gy;
   logic [ABS_W-1:0]         ax_ff, ay_ff;

   always_comb begin
      gx = GRAD_W'(win_ff[2]) + GRAD_W'(win_ff[5]) + GRAD_W'(win_ff[8])
         - GRAD_W'(win_ff[0]) - GRAD_W'(win_ff[3]) - GRAD_W'(win_ff[6]);
      gy = GRAD_W'(win_ff[6]) + GRAD_W'(win_ff[7]) + GRAD_W'(win_ff[8])
         - GRAD_W'(win_ff[0]) - GRAD_W'(win_ff[1]) - GRAD_W'(win_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_grad) begin
         ax_ff <= gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
         ay_ff <= gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
      end
   end

   // sum of squares, one bit pair of the radicand per root step
   logic [SQ_W-1:0]   sq_sum;
   logic [SQ_W+1:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SQ_W:0]     rad_ff;
   logic [IT_W-1:0]   iter_ff;
   logic [SQ_W+1:0]   trial;
   logic [SQ_W+1:0]   rem_shift;

   assign sq_sum = SQ_W'(ax_ff) * SQ_W'(ax_ff) + SQ_W'(ay_ff) * SQ_W'(ay_ff);

   always_comb begin
      rem_shift = {rem_ff[SQ_W-1:0], rad_ff[SQ_W:SQ_W-1]};
      trial     = {{(SQ_W + 2 - ROOT_W - 2){1'b0}}, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rad_ff  <= {1'b0, sq_sum};
         rem_ff  <= '0;
         root_ff <= '0;
         iter_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[SQ_W-2:0], 2'b00};
         iter_ff <= iter_ff + IT_W'(1);
         if (rem_shift >= trial) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // The last step is taken in the cycle that reports done.
   assign status.root_done = iter_ff == IT_W'(ROOT_W - 1);
   assign status.interior  = interior_ff;
   assign status.euclid    = euclid_ff;

   // output register
   logic [ABS_W:0]     l1_sum;
   logic [PIX_W-1:0]   mag_ff;
   logic [ROW_W-1:0]   row_out_ff;
   logic [COL_W-1:0]   col_out_ff;
   logic               last_out_ff;

   assign l1_sum = {1'b0, ax_ff} + {1'b0, ay_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (euclid_ff) begin
            mag_ff <= (root_ff > ROOT_W'(255)) ? 8'hFF : root_ff[PIX_W-1:0];
         end else begin
            mag_ff <= (l1_sum > (ABS_W+1)'(255)) ? 8'hFF : l1_sum[PIX_W-1:0];
         end
         row_out_ff  <= ROW_W'(cur_row_ff - HW'(1));
         col_out_ff  <= COL_W'(cur_col_ff - CW'(1));
         last_out_ff <= last_ff;
      end
   end

   assign rsp_magnitude     = mag_ff;
   assign rsp_row           = row_out_ff;
   assign rsp_col           = col_out_ff;
   assign rsp_last_of_frame = last_out_ff;

endmodule

/* design/prewitt_edge_magnitude_top.sv */
// Streaming 3x3 Prewitt edge detector for 8-bit grayscale pixels in raster
// order. A new request is taken only once the last one is through. The time
// a request takes, with no result, in sum-of-absolute mode or in square-root
// mode, is set by the registered line store read and the bit-serial square
// root that retires one result bit per cycle. Results carry the row and
// column of the window centre and are held in an output register until
// taken; border pixels give no result.
module prewitt_edge_magnitude_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pem_pkg::PIX_W-1:0]   req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pem_pkg::PIX_W-1:0]   rsp_magnitude,
   output logic [pem_pkg::ROW_W-1:0]   rsp_row,
   output logic [pem_pkg::COL_W-1:0]   rsp_col,
   output logic                        rsp_last_of_frame,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [pem_pkg::CFG_W-1:0]   csr_data
);
   import pem_pkg::*;

   cmd_type    cmd;
   status_type status;

   pem_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   pem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_pixel        (req_pixel),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_magnitude    (rsp_magnitude),
      .rsp_row          (rsp_row),
      .rsp_col          (rsp_col),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

endmodule
